// ===== rtl/core/slcd_pkg.sv =====
package slcd_pkg;

    localparam int LINE_MAX_DEF = 32;

    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_UART    = 2'd1;
    localparam logic [1:0] CMD_TX_DONE = 2'd2;
    localparam logic [1:0] CMD_RX_ERR  = 2'd3;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_RESET = 2'd2;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef enum logic [2:0] {
        OP_BYTE,
        OP_EOL,
        OP_UART_ERR,
        OP_TX_DONE,
        OP_RX_ERR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       done_extended;
        logic       done_ok;
        logic       fault_detail;
    } t_item;

    // Upper bit flags a character that is not an uppercase hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= "0" && c <= "9") begin
            v = {1'b0, 4'(c - "0")};
        end else if (c >= "A" && c <= "F") begin
            v = {1'b0, 4'(c - "A" + 8'd10)};
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        c = (n < 4'd10) ? (8'("0") + {4'd0, n}) : (8'("A") + {4'd0, n} - 8'd10);
        return c;
    endfunction

    function automatic logic [7:0] reset_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd1:    c = "R";
            4'd2:    c = "E";
            4'd3:    c = "S";
            4'd4:    c = "E";
            4'd5:    c = "T";
            4'd6:    c = "N";
            4'd7:    c = "O";
            4'd8:    c = "W";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/slcan_command_decoder_unit.sv =====
// Serial-line CAN command decoder. Each transfer on the input carries a received
// ASCII byte or a CAN/UART event; each transfer on the output carries one reply
// character, one frame to send, or a reset request, with o_last on the final one.
// An ordinary byte is stored when the command engine pops it. A carriage return
// walks the stored line through the single read port of the line memory, a read
// and a process state per stored byte, then decides and emits each result into
// a free output slot. A two-entry queue sits between input stage and engine.
module slcan_command_decoder_unit
    import slcd_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_done_extended,
    input  logic        i_done_ok,
    input  logic        i_fault_detail,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_reply_char,
    output logic [28:0] o_frame_id,
    output logic        o_frame_extended,
    output logic        o_frame_remote,
    output logic [3:0]  o_frame_dlc,
    output logic [63:0] o_frame_data,
    output logic [3:0]  o_bitrate_code,
    output logic        o_last
);

    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;
    t_item f_item;
    t_item q_item;

    slcd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_data_byte     (i_data_byte),
        .i_done_extended (i_done_extended),
        .i_done_ok       (i_done_ok),
        .i_fault_detail  (i_fault_detail),
        .o_push          (push),
        .o_item          (f_item),
        .i_q_full        (q_full)
    );

    slcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    slcd_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_item         (q_item),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_reply_char     (o_reply_char),
        .o_frame_id       (o_frame_id),
        .o_frame_extended (o_frame_extended),
        .o_frame_remote   (o_frame_remote),
        .o_frame_dlc      (o_frame_dlc),
        .o_frame_data     (o_frame_data),
        .o_bitrate_code   (o_bitrate_code),
        .o_last           (o_last)
    );

endmodule

// ===== rtl/core/slcd_front.sv =====
module slcd_front
    import slcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic       i_done_extended,
    input  logic       i_done_ok,
    input  logic       i_fault_detail,
    output logic       o_push,
    output t_item      o_item,
    input  logic       i_q_full
);

    logic  r_valid;
    t_item r_item;
    t_op   n_op;

    always_comb begin
        unique case (i_cmd)
            CMD_BYTE:    n_op = (i_data_byte == CH_CR) ? OP_EOL : OP_BYTE;
            CMD_UART:    n_op = OP_UART_ERR;
            CMD_TX_DONE: n_op = OP_TX_DONE;
            default:     n_op = OP_RX_ERR;
        endcase
    end

    assign o_push     = r_valid && !i_q_full;
    assign o_in_ready = !r_valid || !i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_valid <= 1'b1;
                r_item  <= '{op: n_op, data_byte: i_data_byte,
                             done_extended: i_done_extended, done_ok: i_done_ok,
                             fault_detail: i_fault_detail};
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/slcd_queue.sv =====
module slcd_queue
    import slcd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== rtl/core/slcd_back.sv =====
module slcd_back
    import slcd_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_reply_char,
    output logic [28:0] o_frame_id,
    output logic        o_frame_extended,
    output logic        o_frame_remote,
    output logic [3:0]  o_frame_dlc,
    output logic [63:0] o_frame_data,
    output logic [3:0]  o_bitrate_code,
    output logic        o_last
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int LW = $clog2(LINE_MAX + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_PROC = 5'b00100,
        S_DEC  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        RSP_NACK,
        RSP_ACK,
        RSP_ACK_BR,
        RSP_F,
        RSP_V,
        RSP_Z,
        RSP_FRAME,
        RSP_RESET
    } t_rsp;

    logic [7:0]    r_line [LINE_MAX];
    logic [7:0]    r_rdata;

    t_state        r_state;
    t_rsp          r_rsp;
    logic [2:0]    r_step;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_idx;
    logic [1:0]    r_mode;
    logic [3:0]    r_brd;
    logic          r_known;
    logic [7:0]    r_flags;
    logic [7:0]    r_fsnap;
    logic          r_zext;

    logic [7:0]    r_c0;
    logic          r_ext;
    logic          r_wok;
    logic [7:0]    r_sdig;
    logic [28:0]   r_id;
    logic          r_bad;
    logic [7:0]    r_dlc;
    logic [63:0]   r_data;

    logic          r_ovalid;
    logic [1:0]    r_okind;
    logic [7:0]    r_ochar;
    logic [28:0]   r_oid;
    logic          r_oext;
    logic          r_ortr;
    logic [3:0]    r_odlc;
    logic [63:0]   r_odata;
    logic [3:0]    r_obr;
    logic          r_olast;

    logic          mem_we;
    logic [4:0]    hv;
    logic [3:0]    expn;
    logic [7:0]    c_sel;
    logic [9:0]    need;
    logic          frame_ok;
    logic          slot_free;
    logic [1:0]    e_kind;
    logic [7:0]    e_char;
    logic [3:0]    e_br;
    logic          e_last;

    assign o_pop = (r_state == S_IDLE) && !i_q_empty;
    assign mem_we = o_pop && (i_q_item.op == OP_BYTE) && (r_len < LW'(LINE_MAX));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line[r_len[AW-1:0]] <= i_q_item.data_byte;
        end
        r_rdata <= r_line[r_idx[AW-1:0]];
    end

    assign hv    = hex_val(r_rdata);
    assign expn  = r_ext ? 4'd9 : 4'd4;
    assign c_sel = (r_len == '0) ? CH_CR : r_c0;
    assign need  = 10'(expn) + {1'b0, r_dlc, 1'b0} + 10'd1;
    assign frame_ok = r_mode[1] && (r_len > LW'(expn)) && (r_dlc <= 8'd8)
                      && (10'(r_len) == need) && !r_bad;
    assign slot_free = !r_ovalid || i_out_ready;

    always_comb begin
        e_kind = KIND_CHAR;
        e_char = CH_BEL;
        e_br   = 4'd0;
        e_last = 1'b1;
        unique case (r_rsp)
            RSP_NACK: e_char = CH_BEL;
            RSP_ACK:  e_char = CH_CR;
            RSP_ACK_BR: begin
                e_char = CH_CR;
                e_br   = r_brd;
            end
            RSP_F: begin
                e_last = (r_step == 3'd3);
                case (r_step)
                    3'd0:    e_char = "F";
                    3'd1:    e_char = hex_char(r_fsnap[7:4]);
                    3'd2:    e_char = hex_char(r_fsnap[3:0]);
                    default: e_char = CH_CR;
                endcase
            end
            RSP_V: begin
                e_last = (r_step == 3'd5);
                case (r_step)
                    3'd0:    e_char = "V";
                    3'd1:    e_char = "4";
                    3'd2:    e_char = "3";
                    3'd3:    e_char = "2";
                    3'd4:    e_char = "1";
                    default: e_char = CH_CR;
                endcase
            end
            RSP_Z: begin
                e_last = (r_step == 3'd1);
                e_char = (r_step == 3'd0) ? (r_zext ? 8'("Z") : 8'("z")) : CH_CR;
            end
            RSP_FRAME: begin
                e_kind = KIND_FRAME;
                e_char = 8'd0;
            end
            default: begin
                e_kind = KIND_RESET;
                e_char = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_mode   <= 2'd0;
            r_brd    <= 4'd0;
            r_known  <= 1'b0;
            r_flags  <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_step <= 3'd0;
                        case (i_q_item.op)
                            OP_BYTE: begin
                                if (r_len < LW'(LINE_MAX)) begin
                                    r_len <= r_len + 1'b1;
                                end else begin
                                    r_flags[1] <= 1'b1;
                                end
                            end
                            OP_EOL: begin
                                r_idx  <= '0;
                                r_wok  <= 1'b1;
                                r_sdig <= 8'd0;
                                r_id   <= 29'd0;
                                r_bad  <= 1'b0;
                                r_dlc  <= 8'd0;
                                r_data <= 64'd0;
                                r_state <= (r_len == '0) ? S_DEC : S_RD;
                            end
                            OP_UART_ERR: r_flags[0] <= 1'b1;
                            OP_TX_DONE: begin
                                r_zext <= i_q_item.done_extended;
                                if (i_q_item.done_ok) begin
                                    r_rsp <= RSP_Z;
                                end else begin
                                    r_flags[5] <= 1'b1;
                                    if (i_q_item.fault_detail) begin
                                        r_flags[4] <= 1'b1;
                                    end
                                    r_rsp <= RSP_NACK;
                                end
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_flags[7] <= 1'b1;
                                if (i_q_item.fault_detail) begin
                                    r_flags[6] <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_RD: r_state <= S_PROC;
                S_PROC: begin
                    if (r_idx == '0) begin
                        r_c0  <= r_rdata;
                        r_ext <= (r_rdata == "T") || (r_rdata == "R");
                    end else begin
                        if (r_idx < LW'(9)) begin
                            r_wok <= r_wok && (r_rdata == reset_char(r_idx[3:0]));
                        end
                        if (r_idx == LW'(1)) begin
                            r_sdig <= r_rdata - CH_ZERO;
                        end
                        if (r_idx < LW'(expn)) begin
                            r_id <= {r_id[24:0], hv[3:0]};
                            if (hv[4] || ((r_idx == LW'(1))
                                    && (hv[3:0] > (r_ext ? 4'd1 : 4'd7)))) begin
                                r_bad <= 1'b1;
                            end
                        end else if (r_idx == LW'(expn)) begin
                            r_dlc <= r_rdata - CH_ZERO;
                        end else begin
                            r_data <= {r_data[59:0], hv[3:0]};
                            if (hv[4]) begin
                                r_bad <= 1'b1;
                            end
                        end
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= (r_idx + 1'b1 == r_len) ? S_DEC : S_RD;
                end
                S_DEC: begin
                    r_rsp   <= RSP_NACK;
                    r_len   <= '0;
                    r_state <= S_EMIT;
                    unique case (c_sel)
                        "O", "L": begin
                            if (r_len == LW'(1) && r_mode == 2'd0 && r_known) begin
                                r_mode <= (c_sel == "O") ? 2'd3 : 2'd1;
                                r_rsp  <= RSP_ACK_BR;
                            end
                        end
                        "C": begin
                            if (r_len == LW'(1)) begin
                                r_mode  <= 2'd0;
                                r_flags <= 8'd0;
                                r_rsp   <= RSP_ACK;
                            end
                        end
                        "F": begin
                            if (r_len == LW'(1) && r_mode != 2'd0) begin
                                r_fsnap <= r_flags;
                                r_flags <= 8'd0;
                                r_rsp   <= RSP_F;
                            end
                        end
                        "V": begin
                            if (r_len <= LW'(1)) begin
                                r_rsp <= RSP_V;
                            end
                        end
                        "S": begin
                            if (r_len == LW'(2) && r_mode == 2'd0 &&
                                (r_sdig == 8'd3 || r_sdig == 8'd4 || r_sdig == 8'd5 ||
                                 r_sdig == 8'd6 || r_sdig == 8'd8)) begin
                                r_brd   <= r_sdig[3:0];
                                r_known <= 1'b1;
                                r_rsp   <= RSP_ACK;
                            end
                        end
                        "t", "T", "r", "R": begin
                            if (frame_ok) begin
                                r_data <= r_data << {4'd8 - r_dlc[3:0], 3'b000};
                                r_rsp  <= RSP_FRAME;
                            end
                        end
                        "W": begin
                            if (r_len == LW'(9) && r_wok) begin
                                r_mode  <= 2'd0;
                                r_brd   <= 4'd0;
                                r_known <= 1'b0;
                                r_flags <= 8'd0;
                                r_rsp   <= RSP_RESET;
                            end
                        end
                        default: r_rsp <= RSP_NACK;
                    endcase
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= e_kind;
                        r_ochar  <= e_char;
                        r_obr    <= e_br;
                        r_olast  <= e_last;
                        r_oid    <= (e_kind == KIND_FRAME) ? r_id : 29'd0;
                        r_oext   <= (e_kind == KIND_FRAME) && r_ext;
                        r_ortr   <= (e_kind == KIND_FRAME) && ((r_c0 == "r") || (r_c0 == "R"));
                        r_odlc   <= (e_kind == KIND_FRAME) ? r_dlc[3:0] : 4'd0;
                        r_odata  <= (e_kind == KIND_FRAME) ? r_data : 64'd0;
                        r_step   <= r_step + 1'b1;
                        if (e_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_kind           = r_okind;
    assign o_reply_char     = r_ochar;
    assign o_frame_id       = r_oid;
    assign o_frame_extended = r_oext;
    assign o_frame_remote   = r_ortr;
    assign o_frame_dlc      = r_odlc;
    assign o_frame_data     = r_odata;
    assign o_bitrate_code   = r_obr;
    assign o_last           = r_olast;

endmodule

// ===== verif/tb_slcan_command_decoder_unit.sv =====
module tb_slcan_command_decoder_unit;
    import slcd_pkg::*;

    localparam int LINE_LEN = 32;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reply_char;
        logic [28:0] frame_id;
        logic        frame_extended;
        logic        frame_remote;
        logic [3:0]  frame_dlc;
        logic [63:0] frame_data;
        logic [3:0]  bitrate_code;
        logic        last;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_cmd;
    logic [7:0]  i_data_byte;
    logic        i_done_extended;
    logic        i_done_ok;
    logic        i_fault_detail;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_kind;
    logic [7:0]  o_reply_char;
    logic [28:0] o_frame_id;
    logic        o_frame_extended;
    logic        o_frame_remote;
    logic [3:0]  o_frame_dlc;
    logic [63:0] o_frame_data;
    logic [3:0]  o_bitrate_code;
    logic        o_last;

    slcan_command_decoder_unit dut (.*);

    logic [7:0] line_buf [LINE_LEN];
    int unsigned line_cnt;
    logic [1:0]  link_bits;
    logic [3:0]  rate_digit;
    logic        rate_valid;
    logic [7:0]  flag_bits;

    t_answer pending_answers[$];
    t_answer step_answers[$];

    int  errors;
    int  answers_seen;
    int  frames_seen;
    int  cycles;
    bit  rx_idle_ok;
    bit  hold_rx;
    int  hold_rx_cycles;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("slcan_command_decoder_unit verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] to_hex(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
    endfunction

    function automatic logic [4:0] from_hex(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 10)};
        return 5'h10;
    endfunction

    function automatic logic [7:0] char_at(input int unsigned i);
        return (i < line_cnt) ? line_buf[i] : 8'h00;
    endfunction

    task automatic push_answer(input logic [1:0] k, input logic [7:0] ch,
                               input logic [28:0] id = 0, input logic ext = 0,
                               input logic rtr = 0, input logic [3:0] dlc = 0,
                               input logic [63:0] data = 0, input logic [3:0] br = 0);
        t_answer a;
        a = '{k, ch, id, ext, rtr, dlc, data, br, 1'b0};
        step_answers.push_back(a);
    endtask

    task automatic clear_decoder_state();
        line_cnt = 0;
        link_bits = 0;
        rate_digit = 0;
        rate_valid = 0;
        flag_bits = 0;
    endtask

    task automatic decode_frame(input logic ext, input logic rtr);
        int unsigned idlen;
        int unsigned dlc;
        logic [4:0] d;
        logic [4:0] hi;
        logic [4:0] lo;
        logic [28:0] id;
        logic [63:0] data;
        idlen = ext ? 9 : 4;
        id = 0;
        data = 0;
        if (!link_bits[1] || line_cnt <= idlen) begin
            push_answer(KIND_CHAR, CH_BEL);
            return;
        end
        dlc = 8'(char_at(idlen) - CH_ZERO);
        if (dlc > 8 || line_cnt != idlen + 2 * dlc + 1) begin
            push_answer(KIND_CHAR, CH_BEL);
            return;
        end
        for (int unsigned i = 1; i < idlen; i++) begin
            d = from_hex(char_at(i));
            if (d[4] || (i == 1 && d > (ext ? 1 : 7))) begin
                push_answer(KIND_CHAR, CH_BEL);
                return;
            end
            id = (id << 4) | d[3:0];
        end
        for (int unsigned i = 0; i < dlc; i++) begin
            hi = from_hex(char_at(idlen + 1 + 2 * i));
            lo = from_hex(char_at(idlen + 2 + 2 * i));
            if (hi[4] || lo[4]) begin
                push_answer(KIND_CHAR, CH_BEL);
                return;
            end
            data |= 64'({hi[3:0], lo[3:0]}) << (56 - 8 * i);
        end
        push_answer(KIND_FRAME, 8'h00, id, ext, rtr, 4'(dlc), data);
    endtask

    task automatic decode_line();
        logic [7:0] c;
        logic [7:0] v;
        c = (line_cnt != 0) ? char_at(0) : CH_CR;
        case (c)
            "O", "L": begin
                if (line_cnt != 1 || link_bits != 0 || !rate_valid) begin
                    push_answer(KIND_CHAR, CH_BEL);
                end else begin
                    link_bits = (c == "O") ? 2'd3 : 2'd1;
                    push_answer(KIND_CHAR, CH_CR, 0, 0, 0, 0, 0, rate_digit);
                end
            end
            "C": begin
                if (line_cnt != 1) begin
                    push_answer(KIND_CHAR, CH_BEL);
                end else begin
                    link_bits = 0;
                    flag_bits = 0;
                    push_answer(KIND_CHAR, CH_CR);
                end
            end
            "F": begin
                if (line_cnt != 1 || link_bits == 0) begin
                    push_answer(KIND_CHAR, CH_BEL);
                end else begin
                    push_answer(KIND_CHAR, "F");
                    push_answer(KIND_CHAR, to_hex(flag_bits[7:4]));
                    push_answer(KIND_CHAR, to_hex(flag_bits[3:0]));
                    flag_bits = 0;
                    push_answer(KIND_CHAR, CH_CR);
                end
            end
            "V": begin
                if (line_cnt > 1) begin
                    push_answer(KIND_CHAR, CH_BEL);
                end else begin
                    push_answer(KIND_CHAR, "V");
                    push_answer(KIND_CHAR, "4");
                    push_answer(KIND_CHAR, "3");
                    push_answer(KIND_CHAR, "2");
                    push_answer(KIND_CHAR, "1");
                    push_answer(KIND_CHAR, CH_CR);
                end
            end
            "S": begin
                v = char_at(1) - CH_ZERO;
                if (line_cnt != 2 || link_bits != 0 ||
                    !(v inside {8'd3, 8'd4, 8'd5, 8'd6, 8'd8})) begin
                    push_answer(KIND_CHAR, CH_BEL);
                end else begin
                    rate_digit = v[3:0];
                    rate_valid = 1;
                    push_answer(KIND_CHAR, CH_CR);
                end
            end
            "t": decode_frame(0, 0);
            "T": decode_frame(1, 0);
            "r": decode_frame(0, 1);
            "R": decode_frame(1, 1);
            "W": begin
                if (line_cnt != 9 || char_at(1) != "R" || char_at(2) != "E" ||
                    char_at(3) != "S" || char_at(4) != "E" || char_at(5) != "T" ||
                    char_at(6) != "N" || char_at(7) != "O" || char_at(8) != "W") begin
                    push_answer(KIND_CHAR, CH_BEL);
                end else begin
                    push_answer(KIND_RESET, 8'h00);
                    clear_decoder_state();
                end
            end
            default: push_answer(KIND_CHAR, CH_BEL);
        endcase
        line_cnt = 0;
    endtask

    task automatic predict_item(input logic [1:0] cmd, input logic [7:0] b,
                                input logic ext, input logic ok, input logic det);
        step_answers.delete();
        case (cmd)
            CMD_BYTE: begin
                if (b == CH_CR) begin
                    decode_line();
                end else if (line_cnt < LINE_LEN) begin
                    line_buf[line_cnt] = b;
                    line_cnt++;
                end else begin
                    flag_bits[1] = 1;
                end
            end
            CMD_UART: flag_bits[0] = 1;
            CMD_TX_DONE: begin
                if (ok) begin
                    push_answer(KIND_CHAR, ext ? "Z" : "z");
                    push_answer(KIND_CHAR, CH_CR);
                end else begin
                    flag_bits[5] = 1;
                    if (det) flag_bits[4] = 1;
                    push_answer(KIND_CHAR, CH_BEL);
                end
            end
            default: begin
                flag_bits[7] = 1;
                if (det) flag_bits[6] = 1;
            end
        endcase
        if (step_answers.size() > 0) step_answers[$].last = 1;
        foreach (step_answers[i]) pending_answers.push_back(step_answers[i]);
    endtask

    bit tx_idle_ok;

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic ext = 0, input logic ok = 0, input logic det = 0);
        int gap;
        if (tx_idle_ok && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1;
        i_cmd = cmd;
        i_data_byte = b;
        i_done_extended = ext;
        i_done_ok = ok;
        i_fault_detail = det;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(cmd, b, ext, ok, det);
        @(negedge i_clk);
        i_in_valid = 0;
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i]);
        send_item(CMD_BYTE, CH_CR);
    endtask

    task automatic drain();
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_rx) begin
            i_out_ready <= 0;
        end else if (rx_idle_ok && hold_rx_cycles == 0 && $urandom_range(0, 7) == 0) begin
            hold_rx_cycles <= $urandom_range(1, 15);
            i_out_ready <= 0;
        end else if (hold_rx_cycles > 0) begin
            hold_rx_cycles <= hold_rx_cycles - 1;
            i_out_ready <= (hold_rx_cycles == 1);
        end else begin
            i_out_ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_kind, o_reply_char, o_frame_id, o_frame_extended, o_frame_remote,
                    o_frame_dlc, o_frame_data, o_bitrate_code, o_last};
            answers_seen++;
            if (o_kind == KIND_FRAME) frames_seen++;
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t unexpected transfer %h", $time, got);
            end else begin
                want = pending_answers.pop_front();
                if (got.kind != want.kind || got.reply_char != want.reply_char ||
                    got.frame_id != want.frame_id ||
                    got.frame_extended != want.frame_extended ||
                    got.frame_remote != want.frame_remote ||
                    got.frame_dlc != want.frame_dlc || got.frame_data != want.frame_data ||
                    got.bitrate_code != want.bitrate_code || got.last != want.last) begin
                    errors++;
                    $display("%0t mismatch expected %h actual %h", $time, want, got);
                end
            end
        end
    end

    function automatic string hex_str(input logic [63:0] v, input int n);
        string s;
        s = "";
        for (int i = n - 1; i >= 0; i--) s = {s, string'(to_hex(v[4 * i +: 4]))};
        return s;
    endfunction

    function automatic string random_frame();
        int kind_sel;
        int dlc;
        logic [28:0] id;
        string s;
        kind_sel = $urandom_range(0, 3);
        dlc = $urandom_range(0, 8);
        id = $urandom;
        if (kind_sel[0]) s = {kind_sel[1] ? "R" : "T", hex_str({35'd0, id}, 8)};
        else s = {kind_sel[1] ? "r" : "t", hex_str({53'd0, id[10:0]}, 3)};
        if (kind_sel[0]) s[1] = (id[28]) ? "1" : "0";
        s = {s, string'(8'(CH_ZERO + dlc))};
        s = {s, hex_str({$urandom, $urandom}, 2 * dlc)};
        return s;
    endfunction

    function automatic string corrupt(input string s);
        int p;
        p = $urandom_range(0, s.len() - 1);
        case ($urandom_range(0, 2))
            0: s[p] = 8'($urandom_range(32, 126));
            1: s = s.substr(0, s.len() - 2);
            default: s = {s, "0"};
        endcase
        return s;
    endfunction

    task automatic test_open_close_directed();
        send_line("");
        send_line("V");
        send_line("VX");
        send_line("O");
        send_line("S9");
        send_line("S3");
        send_line("S8");
        send_line("O");
        send_line("S4");
        send_line("O");
        send_line("F");
        send_line("C");
        send_line("L");
        send_line("t1230");
        send_line("X");
        send_line("CC");
    endtask

    task automatic test_frames_and_events();
        send_line("C");
        send_line("S6");
        send_line("O");
        send_line("t7FF8FFEEDDCCBBAA9988");
        send_line("T1FFFFFFF0");
        send_line("r0001");
        send_line("R000000002ab");
        send_line("t8000");
        send_line("ta000");
        send_item(CMD_TX_DONE, 0, 1, 1, 0);
        send_item(CMD_TX_DONE, 0, 0, 1, 1);
        send_item(CMD_TX_DONE, 0, 0, 0, 1);
        send_item(CMD_TX_DONE, 0, 1, 0, 0);
        send_item(CMD_UART, 8'hFF, 1, 1, 1);
        send_item(CMD_RX_ERR, 8'h00, 0, 0, 1);
        send_item(CMD_RX_ERR, 8'h00, 0, 0, 0);
        send_line("F");
        send_line("WRESETNOX");
        send_line("WRESETNOW");
        send_line("F");
    endtask

    task automatic test_overlong_line();
        send_line("S5");
        send_line("O");
        for (int i = 0; i < LINE_LEN + 4; i++) send_item(CMD_BYTE, 8'($urandom_range(14, 255)));
        send_item(CMD_BYTE, CH_CR);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, CH_CR);
        send_line("F");
    endtask

    task automatic test_backpressure();
        drain();
        hold_rx = 1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_rx = 0;
            end
            for (int i = 0; i < 10; i++) send_line("V");
        join
        drain();
    endtask

    task automatic test_random_traffic(input int n_items, input bit idle);
        int sent;
        string s;
        tx_idle_ok = idle;
        rx_idle_ok = idle;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    s = random_frame();
                    if ($urandom_range(0, 3) == 0) s = corrupt(s);
                end
                8: s = {"S", string'(8'($urandom_range(48, 57)))};
                9: s = ($urandom_range(0, 1) != 0) ? "O" : "L";
                10: s = "C";
                11: s = "F";
                12: s = "V";
                13: s = ($urandom_range(0, 3) == 0) ? "WRESETNOW" : "WRESET";
                14: begin
                    s = "";
                    repeat ($urandom_range(0, 5)) s = {s, string'(8'($urandom_range(0, 255)))};
                    s = {s, string'(8'($urandom_range(14, 255)))};
                end
                default: begin
                    send_item(2'($urandom_range(1, 3)), 8'($urandom),
                              1'($urandom), 1'($urandom), 1'($urandom));
                    sent++;
                    continue;
                end
            endcase
            for (int i = 0; i < s.len(); i++) begin
                if (s[i] != CH_CR) send_item(CMD_BYTE, s[i]);
            end
            send_item(CMD_BYTE, CH_CR);
            sent += s.len() + 1;
        end
        drain();
    endtask

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_ready = 0;
        i_cmd = CMD_BYTE;
        i_data_byte = 0;
        i_done_extended = 0;
        i_done_ok = 0;
        i_fault_detail = 0;
        errors = 0;
        answers_seen = 0;
        frames_seen = 0;
        cycles = 0;
        hold_rx = 0;
        hold_rx_cycles = 0;
        rx_idle_ok = 1;
        tx_idle_ok = 1;
        clear_decoder_state();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        test_open_close_directed();
        test_frames_and_events();
        test_overlong_line();
        test_backpressure();
        test_random_traffic(60, 1);
        test_random_traffic(30, 0);

        drain();
        $display("Covered link commands, frame encodes, flag reports, events, resets,");
        $display("overlong lines and stalls: %0d results, %0d frames.",
                 answers_seen, frames_seen);
        if (errors == 0) begin
            $display("slcan_command_decoder_unit verification clean");
        end else begin
            $display("slcan_command_decoder_unit verification failed");
        end
        $finish;
    end

endmodule
